// ===== hdl/text_console_char_writer_defines.svh =====
// Assertion macros for the text console character writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TCW_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("text_console_char_writer: assertion failed");
`define TCW_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("text_console_char_writer: reset assertion failed");
`else
`define TCW_ASSERT(label, prop)
`define TCW_ASSERT_RST(label, prop)
`endif

`endif

// ===== hdl/tcw_pkg.sv =====
// Types, constants and helpers for the text console character writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int SCREEN  = COLUMNS * ROWS;

    localparam int TAB_STEP = 8;
    localparam int TAB_W    = $clog2(TAB_STEP + 1);

    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;

    localparam int ADDR_W = $clog2(SCREEN);
    localparam int CUR_W  = $clog2(SCREEN + TAB_STEP);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CMP_W  = (CUR_W > IDX_W) ? CUR_W : IDX_W;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7F;
    localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CUR_W-1:0]  CUR_COLUMNS = CUR_W'(COLUMNS);
    localparam logic [CUR_W-1:0]  CUR_SCREEN  = CUR_W'(SCREEN);
    localparam logic [CUR_W-1:0]  TAB_MASK    = ~CUR_W'(TAB_STEP - 1);
    localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ADDR_COLUMNS = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] ADDR_LAST    = ADDR_W'(SCREEN - 1);

    typedef struct packed {
        logic              operation;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CHAR_W-1:0] cell_data;
        logic              scrolled;
    } t_out_item;

    typedef struct packed {
        logic [CUR_W-1:0] cursor;
        logic [COL_W-1:0] col;
        logic             wr_en;
        logic             scroll;
    } t_cursor_next;

    // Maps a logical cell offset onto the rotated physical store.
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] off,
                                                    input logic [ADDR_W-1:0] base);
        logic [ADDR_W:0] sum;
        sum = {1'b0, off} + {1'b0, base};
        if (sum >= (ADDR_W+1)'(SCREEN)) begin
            sum = sum - (ADDR_W+1)'(SCREEN);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== hdl/text_console_char_writer.sv =====
// Top level of the text console character writer: control, row rotation and result register.
//
// A printable put character is written straight into the screen store, and a cell read goes
// through the single registered read port of the store. A put that scrolls is followed by a
// row refill, because rows rotate by a base offset and the recycled row is rewritten with
// spaces one cell per cycle. After reset a clearing pass fills the whole store with spaces
// before the first item is taken.
`include "text_console_char_writer_defines.svh"

module text_console_char_writer
    import tcw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [ADDR_W-1:0] r_fill_addr, n_fill_addr;
    logic [ADDR_W-1:0] r_fill_last, n_fill_last;
    logic              r_rd_valid, n_rd_valid;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_cursor_next      cur_next;
    logic              accept;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  cur_ext;
    logic [ADDR_W:0]   base_sum;

    tcw_cursor u_cursor (
        .i_cursor (r_cursor),
        .i_col    (r_col),
        .i_code   (i_in_data.char_code),
        .o_next   (cur_next)
    );

    tcw_screen_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign idx_ext    = CMP_W'(i_in_data.cell_index);
    assign cur_ext    = CMP_W'(r_cursor);
    assign mem_raddr  = phys_addr(idx_ext[ADDR_W-1:0], r_base);
    assign base_sum   = {1'b0, r_base} + {1'b0, ADDR_COLUMNS};

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_base      = r_base;
        n_fill_addr = r_fill_addr;
        n_fill_last = r_fill_last;
        n_rd_valid  = r_rd_valid;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_fill_addr;
        mem_wdata   = SPACE_CODE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.operation == OP_READ) begin
                        n_rd_valid = (idx_ext < CMP_W'(SCREEN));
                        n_state    = S_READ;
                    end else begin
                        mem_we      = cur_next.wr_en;
                        mem_waddr   = phys_addr(r_cursor[ADDR_W-1:0], r_base);
                        mem_wdata   = i_in_data.char_code;
                        n_cursor    = cur_next.cursor;
                        n_col       = cur_next.col;
                        n_out_valid = 1'b1;
                        n_out.cursor_position = POS_W'(CMP_W'(cur_next.cursor));
                        n_out.cell_data       = '0;
                        n_out.scrolled        = cur_next.scroll;
                        if (cur_next.scroll) begin
                            n_fill_addr = r_base;
                            n_fill_last = r_base + ADDR_W'(COLUMNS - 1);
                            n_base      = (base_sum >= (ADDR_W+1)'(SCREEN)) ?
                                          '0 : base_sum[ADDR_W-1:0];
                            n_state     = S_FILL;
                        end
                    end
                end
            end
            S_READ: begin
                n_out_valid           = 1'b1;
                n_out.cursor_position = cur_ext[POS_W-1:0];
                n_out.cell_data       = r_rd_valid ? mem_rdata : '0;
                n_out.scrolled        = 1'b0;
                n_state               = S_IDLE;
            end
            S_FILL: begin
                mem_we = 1'b1;
                if (r_fill_addr == r_fill_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_fill_addr = r_fill_addr + ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_cursor    <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_fill_addr <= '0;
            r_fill_last <= ADDR_LAST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_base      <= n_base;
            r_fill_addr <= n_fill_addr;
            r_fill_last <= n_fill_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= n_rd_valid;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TCW_ASSERT(a_cursor_on_screen, r_cursor < CUR_SCREEN)
    `TCW_ASSERT(a_read_takes_port, (accept && i_in_data.operation == OP_READ) |=> (r_state == S_READ && !r_out_valid))
    `TCW_ASSERT(a_scroll_cursor_bottom, (r_out_valid && r_out.scrolled) |-> (r_cursor >= CUR_SCREEN - CUR_COLUMNS))
    `TCW_ASSERT_RST(a_reset_clears, !i_rst_n |=> (r_state == S_FILL && !o_out_valid))

endmodule

// ===== hdl/tcw_screen_ram.sv =====
// Screen cell store: one write port and one registered read port.
module tcw_screen_ram
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [CHAR_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [SCREEN];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tcw_cursor.sv =====
// Next cursor offset and column for one put character, with scroll detection.
module tcw_cursor
    import tcw_pkg::*;
(
    input  logic [CUR_W-1:0]  i_cursor,
    input  logic [COL_W-1:0]  i_col,
    input  logic [CHAR_W-1:0] i_code,
    output t_cursor_next      o_next
);

    logic [CUR_W-1:0] cur_pre;
    logic [COL_W-1:0] col_pre;
    logic             wr_en;
    logic [CUR_W-1:0] tab_new;
    logic [TAB_W-1:0] tab_delta;
    logic [COL_W:0]   col_sum;
    logic             scroll;

    always_comb begin
        cur_pre   = i_cursor;
        col_pre   = i_col;
        wr_en     = 1'b0;
        tab_new   = (i_cursor + CUR_W'(TAB_STEP)) & TAB_MASK;
        tab_delta = TAB_W'(tab_new - i_cursor);
        col_sum   = {1'b0, i_col} + (COL_W+1)'(tab_delta);
        unique case (i_code)
            CODE_BS: begin
                if (i_cursor != '0) begin
                    cur_pre = i_cursor - CUR_W'(1);
                    col_pre = (i_col == '0) ? COL_LAST : i_col - COL_W'(1);
                end
            end
            CODE_TAB: begin
                cur_pre = tab_new;
                if (col_sum >= (COL_W+1)'(COLUMNS)) begin
                    col_pre = COL_W'(col_sum - (COL_W+1)'(COLUMNS));
                end else begin
                    col_pre = col_sum[COL_W-1:0];
                end
            end
            CODE_CR: begin
                cur_pre = i_cursor - CUR_W'(i_col);
                col_pre = '0;
            end
            CODE_LF: begin
                cur_pre = i_cursor + (CUR_COLUMNS - CUR_W'(i_col));
                col_pre = '0;
            end
            default: begin
                if (i_code >= SPACE_CODE && i_code <= PRINT_HI) begin
                    wr_en   = 1'b1;
                    cur_pre = i_cursor + CUR_W'(1);
                    col_pre = (i_col == COL_LAST) ? '0 : i_col + COL_W'(1);
                end
            end
        endcase
        scroll = (cur_pre >= CUR_SCREEN);
    end

    assign o_next.cursor = scroll ? cur_pre - CUR_COLUMNS : cur_pre;
    assign o_next.col    = col_pre;
    assign o_next.wr_en  = wr_en;
    assign o_next.scroll = scroll;

endmodule

// ===== tb/tb_text_console_char_writer.sv =====
// Testbench for the text console character writer: directed and random character traffic checked against a cycle-free screen predictor.
`timescale 1ns / 1ps

module tb_text_console_char_writer;
    import tcw_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 500000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      o_in_ready;
    t_in_item  in_data;
    logic      o_out_valid;
    logic      out_ready;
    t_out_item o_out_data;

    logic [CHAR_W-1:0] screen_now [0:SCREEN-1];
    int unsigned       cursor_now;

    t_in_item  char_items [$];
    t_out_item owed_reports [$];

    bit in_taken;
    bit out_taken;
    bit in_calm;
    bit out_calm;
    int in_gap;
    int out_stall;
    int fail_count;
    int cycle_count;

    text_console_char_writer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_out_item apply_console_item(input t_in_item item);
        t_out_item   rep;
        int unsigned cur;
        cur = cursor_now;
        rep = '0;
        if (item.operation == OP_PUT) begin
            case (item.char_code)
                CODE_BS: begin
                    if (cur > 0) cur = cur - 1;
                end
                CODE_TAB: begin
                    cur = (cur + TAB_STEP) & ~(TAB_STEP - 1);
                end
                CODE_CR: begin
                    cur = cur - (cur % COLUMNS);
                end
                CODE_LF: begin
                    cur = cur + COLUMNS - (cur % COLUMNS);
                end
                default: begin
                    if (item.char_code >= SPACE_CODE && item.char_code <= PRINT_HI) begin
                        if (cur < SCREEN) screen_now[cur] = item.char_code;
                        cur = cur + 1;
                    end
                end
            endcase
            if (cur >= SCREEN) begin
                for (int k = 0; k < SCREEN - COLUMNS; k++) screen_now[k] = screen_now[k + COLUMNS];
                for (int k = SCREEN - COLUMNS; k < SCREEN; k++) screen_now[k] = SPACE_CODE;
                cur = cur - COLUMNS;
                if (cur >= SCREEN) cur = SCREEN - 1;
                rep.scrolled = 1'b1;
            end
        end else if (item.cell_index < SCREEN) begin
            rep.cell_data = screen_now[item.cell_index];
        end
        cursor_now = cur;
        rep.cursor_position = POS_W'(cur);
        return rep;
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int          pick;
        int          sel;
        int unsigned lo;
        it.operation  = OP_PUT;
        it.char_code  = CHAR_W'($urandom_range(0, 255));
        it.cell_index = IDX_W'($urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            it.operation = OP_READ;
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                lo = (cursor_now > COLUMNS) ? cursor_now - COLUMNS : 0;
                it.cell_index = IDX_W'($urandom_range(lo, cursor_now));
            end else if (sel < 8) begin
                it.cell_index = IDX_W'($urandom_range(0, SCREEN - 1));
            end
        end else if (pick < 70) begin
            it.char_code = CHAR_W'($urandom_range(SPACE_CODE, PRINT_HI));
        end else if (pick < 83) begin
            it.char_code = CODE_LF;
        end else if (pick < 86) begin
            it.char_code = CODE_CR;
        end else if (pick < 91) begin
            it.char_code = CODE_TAB;
        end else if (pick < 95) begin
            it.char_code = CODE_BS;
        end
        return it;
    endfunction

    task automatic queue_item(input logic op, input int code, input int idx);
        t_in_item it;
        it.operation  = op;
        it.char_code  = CHAR_W'(code);
        it.cell_index = IDX_W'(idx);
        char_items.push_back(it);
    endtask

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        in_taken  = i_rst_n && in_valid && o_in_ready;
        out_taken = i_rst_n && o_out_valid && out_ready;
        if (in_taken) begin
            owed_reports.push_back(apply_console_item(in_data));
        end
        if (out_taken) begin
            if (owed_reports.size() == 0) begin
                $error("unexpected transfer: cursor_position %0d cell_data %0h scrolled %0b",
                       o_out_data.cursor_position, o_out_data.cell_data, o_out_data.scrolled);
                fail_count = fail_count + 1;
            end else begin
                t_out_item want;
                want = owed_reports.pop_front();
                if (o_out_data.cursor_position !== want.cursor_position) begin
                    $error("cursor_position: expected %0d, actual %0d",
                           want.cursor_position, o_out_data.cursor_position);
                    fail_count = fail_count + 1;
                end
                if (o_out_data.cell_data !== want.cell_data) begin
                    $error("cell_data: expected %0h, actual %0h",
                           want.cell_data, o_out_data.cell_data);
                    fail_count = fail_count + 1;
                end
                if (o_out_data.scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0b, actual %0b",
                           want.scrolled, o_out_data.scrolled);
                    fail_count = fail_count + 1;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_valid || in_taken) begin
                if (in_valid) begin
                    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
                    in_gap = draw_wait(in_calm);
                end
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end else if (char_items.size() != 0) begin
                    in_data  <= char_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
                out_stall = draw_wait(out_calm);
            end
            if (out_stall > 0) begin
                out_stall = out_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        in_taken    = 1'b0;
        out_taken   = 1'b0;
        in_calm     = 1'b0;
        out_calm    = 1'b1;
        in_gap      = 0;
        out_stall   = 0;
        fail_count  = 0;
        cycle_count = 0;
        cursor_now  = 0;
        for (int k = 0; k < SCREEN; k++) screen_now[k] = SPACE_CODE;

        queue_item(OP_READ, 8'hFF, 0);
        queue_item(OP_READ, 8'h00, SCREEN - 1);
        queue_item(OP_READ, 8'h41, SCREEN);
        queue_item(OP_READ, 8'h00, 2047);
        queue_item(OP_PUT, CODE_BS, 2047);
        queue_item(OP_PUT, 8'h41, 0);
        queue_item(OP_PUT, PRINT_HI, 0);
        queue_item(OP_PUT, SPACE_CODE, 0);
        queue_item(OP_PUT, 8'h00, 0);
        queue_item(OP_PUT, 8'h1F, 0);
        queue_item(OP_PUT, 8'h80, 0);
        queue_item(OP_PUT, 8'hFF, 0);
        queue_item(OP_PUT, CODE_TAB, 0);
        queue_item(OP_PUT, CODE_BS, 0);
        queue_item(OP_PUT, CODE_CR, 0);
        queue_item(OP_PUT, CODE_LF, 0);
        queue_item(OP_PUT, 8'h7E, 0);
        queue_item(OP_READ, 8'h00, 0);
        queue_item(OP_READ, 8'h00, 1);
        queue_item(OP_READ, 8'h00, COLUMNS);
        queue_item(OP_PUT, CODE_TAB, 0);
        queue_item(OP_PUT, CODE_LF, 0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            while (char_items.size() != 0) @(posedge i_clk);
            char_items.push_back(random_item());
        end
        while (char_items.size() != 0 || in_valid) @(posedge i_clk);
        while (owed_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== text_console_char_writer.f =====
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_screen_ram.sv
hdl/tcw_cursor.sv
hdl/text_console_char_writer.sv
tb/tb_text_console_char_writer.sv
